// ----- design/emem_pkg.sv -----
package emem_pkg;

  localparam int unsigned DEF_MEM_WORDS = 2048;
  localparam int unsigned DEF_NUM_PORTS = 4;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PORT_W  = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned S_TDATA_W = 40;

  // control word layout
  localparam int unsigned CTL_PTR_LSB    = 2;
  localparam int unsigned CTL_PTR_MSB    = 14;
  localparam int unsigned CTL_PTR_W      = CTL_PTR_MSB - CTL_PTR_LSB + 1;
  localparam int unsigned CTL_INC_WR_BIT = 24;
  localparam int unsigned CTL_INC_RD_BIT = 25;

  typedef enum logic [CMD_W-1:0] {
    CMD_CTL   = 2'd0,
    CMD_WDATA = 2'd1,
    CMD_RDATA = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RDWAIT
  } state_e;

  typedef struct packed {
    logic start_ctl;
    logic step;
    logic commit_ctl;
    logic mem_wr;
    logic mem_rd;
    logic out_zero;
    logic out_mem;
  } dp_cmd_t;

  typedef struct packed {
    logic port_ok;
    logic red_last;
  } dp_stat_t;

endpackage

// ----- design/emem_auto_increment_access_port.sv -----
// channel  dir  tdata fields (lsb first)
// s_axis   in   command[1:0], port[3:2], write_word[35:4], zero pad [39:36]
// m_axis   out  read_word[31:0]
//
// One word at a time. Data write and unused command/port: zero word loaded on accept; data
// read: registered memory read, then output load. Control write: accept, quotient of the
// pointer field by MEM_WORDS from a reciprocal multiply, then remainder and pointer load.
// Async active-low reset clears pointers and increment flags; memory is not cleared.
// Input accepted while a result waits in the output register if m_axis takes it.
module emem_auto_increment_access_port #(
  parameter int unsigned MEM_WORDS = emem_pkg::DEF_MEM_WORDS,
  parameter int unsigned NUM_PORTS = emem_pkg::DEF_NUM_PORTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [emem_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // command, port, write_word
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [emem_pkg::WORD_W-1:0]     m_axis_tdata   // read_word
);

  emem_pkg::dp_cmd_t  cmd;
  emem_pkg::dp_stat_t stat;

  emem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .cmd_code_i  (s_axis_tdata[1:0]),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  emem_dp #(
    .MEM_WORDS (MEM_WORDS),
    .NUM_PORTS (NUM_PORTS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .port_i  (s_axis_tdata[3:2]),
    .word_i  (s_axis_tdata[35:4]),
    .stat_o  (stat),
    .rdata_o (m_axis_tdata)
  );

  a_rd_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_rd |=> cmd.out_mem)
    else $error("read data not loaded after memory read");

  a_commit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit_ctl |-> (stat.red_last && cmd.step))
    else $error("pointer committed before reduction finished");

  a_bad_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !stat.port_ok)
      |=> (m_axis_tvalid && (m_axis_tdata == '0)))
    else $error("unused port did not give a zero word");

endmodule

// ----- design/emem_ram.sv -----
module emem_ram #(
  parameter int unsigned DEPTH = emem_pkg::DEF_MEM_WORDS,
  parameter int unsigned AW    = $clog2(emem_pkg::DEF_MEM_WORDS),
  parameter int unsigned DW    = emem_pkg::WORD_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/emem_dp.sv -----
module emem_dp #(
  parameter int unsigned MEM_WORDS = emem_pkg::DEF_MEM_WORDS,
  parameter int unsigned NUM_PORTS = emem_pkg::DEF_NUM_PORTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  emem_pkg::dp_cmd_t              cmd_i,
  input  logic [emem_pkg::PORT_W-1:0]    port_i,
  input  logic [emem_pkg::WORD_W-1:0]    word_i,
  output emem_pkg::dp_stat_t             stat_o,
  output logic [emem_pkg::WORD_W-1:0]    rdata_o
);

  localparam int unsigned AW     = $clog2(MEM_WORDS);
  localparam int unsigned FW     = emem_pkg::CTL_PTR_W;
  localparam int unsigned MW     = FW + 1;
  localparam int unsigned SH     = FW + AW;
  localparam int unsigned RCP_W  = FW + 2;
  localparam int unsigned PROD_W = FW + RCP_W;
  localparam int unsigned QM_W   = FW + MW;
  localparam int unsigned PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned PCMP_W = ($clog2(NUM_PORTS + 1) > emem_pkg::PORT_W) ?
                                   $clog2(NUM_PORTS + 1) : emem_pkg::PORT_W;
  localparam logic [RCP_W-1:0] RECIP   = RCP_W'(((32'd1 << SH) + MEM_WORDS - 1) / MEM_WORDS);
  localparam logic [MW-1:0]    DIVISOR = MW'(MEM_WORDS);
  localparam logic [AW-1:0]    PTR_MAX = AW'(MEM_WORDS - 1);

  logic [AW-1:0]     ptr_q [NUM_PORTS];
  logic              rd_inc_q [NUM_PORTS];
  logic              wr_inc_q [NUM_PORTS];
  logic [PIDX_W-1:0] pidx;
  logic [PIDX_W-1:0] port_q;
  logic [AW-1:0]     cur_ptr;
  logic [AW-1:0]     ptr_inc;
  logic [FW-1:0]     r_q;
  logic [FW-1:0]     q_q;
  logic              k_q;
  logic [PROD_W-1:0] prod;
  logic [QM_W-1:0]   qm;
  logic [FW-1:0]     rem;
  logic [emem_pkg::WORD_W-1:0] ram_rdata;
  logic [emem_pkg::WORD_W-1:0] out_q;

  assign pidx    = PIDX_W'(port_i);
  assign cur_ptr = ptr_q[pidx];
  assign ptr_inc = (cur_ptr == PTR_MAX) ? '0 : cur_ptr + 1'b1;

  assign stat_o.port_ok  = PCMP_W'(port_i) < PCMP_W'(NUM_PORTS);
  assign stat_o.red_last = !k_q;

  // pointer field modulo MEM_WORDS: quotient by reciprocal multiply, then r - q*M
  assign prod = PROD_W'(r_q) * PROD_W'(RECIP);
  assign qm   = QM_W'(q_q) * QM_W'(DIVISOR);
  assign rem  = r_q - qm[FW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_ctl) begin
      r_q    <= word_i[emem_pkg::CTL_PTR_MSB:emem_pkg::CTL_PTR_LSB];
      k_q    <= 1'b1;
      port_q <= pidx;
    end else if (cmd_i.step) begin
      q_q <= FW'(prod >> SH);
      k_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        ptr_q[i]    <= '0;
        rd_inc_q[i] <= 1'b0;
        wr_inc_q[i] <= 1'b0;
      end
    end else begin
      if (cmd_i.start_ctl) begin
        rd_inc_q[pidx] <= word_i[emem_pkg::CTL_INC_RD_BIT];
        wr_inc_q[pidx] <= word_i[emem_pkg::CTL_INC_WR_BIT];
      end
      if (cmd_i.commit_ctl) begin
        ptr_q[port_q] <= rem[AW-1:0];
      end
      if ((cmd_i.mem_wr && wr_inc_q[pidx]) || (cmd_i.mem_rd && rd_inc_q[pidx])) begin
        ptr_q[pidx] <= ptr_inc;
      end
    end
  end

  emem_ram #(
    .DEPTH (MEM_WORDS),
    .AW    (AW),
    .DW    (emem_pkg::WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_wr),
    .re_i    (cmd_i.mem_rd),
    .addr_i  (cur_ptr),
    .wdata_i (word_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_zero) begin
      out_q <= '0;
    end else if (cmd_i.out_mem) begin
      out_q <= ram_rdata;
    end
  end

  assign rdata_o = out_q;

endmodule

// ----- design/emem_ctrl.sv -----
module emem_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [emem_pkg::CMD_W-1:0]   cmd_code_i,
  input  logic                         out_ready_i,
  input  emem_pkg::dp_stat_t           stat_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  output emem_pkg::dp_cmd_t            cmd_o
);

  emem_pkg::state_e state_q, state_d;
  logic             out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= emem_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == emem_pkg::ST_IDLE) && (!out_vld_q || out_ready_i);
    unique case (state_q)
      emem_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (!stat_i.port_ok) begin
            cmd_o.out_zero = 1'b1;
          end else begin
            case (emem_pkg::cmd_e'(cmd_code_i))
              emem_pkg::CMD_CTL: begin
                cmd_o.start_ctl = 1'b1;
                state_d         = emem_pkg::ST_REDUCE;
              end
              emem_pkg::CMD_WDATA: begin
                cmd_o.mem_wr   = 1'b1;
                cmd_o.out_zero = 1'b1;
              end
              emem_pkg::CMD_RDATA: begin
                cmd_o.mem_rd = 1'b1;
                state_d      = emem_pkg::ST_RDWAIT;
              end
              default: begin
                cmd_o.out_zero = 1'b1;
              end
            endcase
          end
        end
      end
      emem_pkg::ST_REDUCE: begin
        cmd_o.step = 1'b1;
        if (stat_i.red_last) begin
          cmd_o.commit_ctl = 1'b1;
          cmd_o.out_zero   = 1'b1;
          state_d          = emem_pkg::ST_IDLE;
        end
      end
      emem_pkg::ST_RDWAIT: begin
        cmd_o.out_mem = 1'b1;
        state_d       = emem_pkg::ST_IDLE;
      end
      default: begin
        state_d = emem_pkg::ST_IDLE;
      end
    endcase
    out_vld_d = (out_vld_q && !out_ready_i) || cmd_o.out_zero || cmd_o.out_mem;
  end

  assign out_valid_o = out_vld_q;

endmodule

// ----- tb/sv/emem_access_checker.sv -----
`timescale 1ns / 100ps

module emem_access_checker #(
  parameter int unsigned MEM_WORDS = emem_pkg::DEF_MEM_WORDS,
  parameter int unsigned NUM_PORTS = emem_pkg::DEF_NUM_PORTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [emem_pkg::S_TDATA_W-1:0]  s_tdata_i,  // command, port, write_word
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [emem_pkg::WORD_W-1:0]     m_tdata_i,  // read_word
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_o
);

  import emem_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [WORD_W-1:0]    word_mem [MEM_WORDS];
  logic [CTL_PTR_W-1:0] word_ptr [NUM_PORTS];
  bit                   rd_step  [NUM_PORTS];
  bit                   wr_step  [NUM_PORTS];
  logic [WORD_W-1:0]    expected_words [$];
  logic [WORD_W-1:0]    oldest;
  int unsigned          mismatches = 0;

  function automatic logic [WORD_W-1:0] access_word(logic [CMD_W-1:0] cmd,
                                                    logic [PORT_W-1:0] port,
                                                    logic [WORD_W-1:0] w);
    logic [AW-1:0]     cur;
    logic [WORD_W-1:0] rd;
    rd = '0;
    if (port < NUM_PORTS) begin
      cur = AW'(word_ptr[port] % MEM_WORDS);
      case (cmd)
        CMD_CTL: begin
          word_ptr[port] = CTL_PTR_W'(w[CTL_PTR_MSB:CTL_PTR_LSB] % MEM_WORDS);
          rd_step[port]  = w[CTL_INC_RD_BIT];
          wr_step[port]  = w[CTL_INC_WR_BIT];
        end
        CMD_WDATA: begin
          word_mem[cur] = w;
          if (wr_step[port]) word_ptr[port] = CTL_PTR_W'((cur + 1) % MEM_WORDS);
        end
        CMD_RDATA: begin
          rd = word_mem[cur];
          if (rd_step[port]) word_ptr[port] = CTL_PTR_W'((cur + 1) % MEM_WORDS);
        end
        default: ;
      endcase
    end
    return rd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        word_ptr[i] = '0;
        rd_step[i]  = 1'b0;
        wr_step[i]  = 1'b0;
      end
      expected_words.delete();
      pending_o <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        expected_words.push_back(access_word(s_tdata_i[CMD_W-1:0],
                                             s_tdata_i[CMD_W +: PORT_W],
                                             s_tdata_i[CMD_W+PORT_W +: WORD_W]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_words.size() == 0) begin
          $error("read_word: no word expected, actual %h", m_tdata_i);
          mismatches++;
        end else begin
          oldest = expected_words.pop_front();
          if (m_tdata_i !== oldest) begin
            $error("read_word: expected %h, actual %h", oldest, m_tdata_i);
            mismatches++;
          end
        end
      end
      pending_o <= expected_words.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  import emem_pkg::*;

  localparam int unsigned MEM_WORDS   = DEF_MEM_WORDS;
  localparam int unsigned NUM_PORTS   = DEF_NUM_PORTS;
  localparam int unsigned AW          = $clog2(MEM_WORDS);
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int unsigned TOTAL_WORDS = 1850;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // command, port, write_word
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [WORD_W-1:0]     m_axis_tdata;       // read_word

  int unsigned mismatches;
  int unsigned pending;

  // stimulus-side pointer tracking, used only to keep reads on written words
  logic [CTL_PTR_W-1:0] ptr_sh [NUM_PORTS];
  bit                   inc_rd_sh [NUM_PORTS];
  bit                   inc_wr_sh [NUM_PORTS];
  bit                   written [MEM_WORDS];

  int unsigned sent = 0;
  bit          sender_idle_en = 1'b1;
  bit          recv_idle_en = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  emem_auto_increment_access_port #(
    .MEM_WORDS(MEM_WORDS),
    .NUM_PORTS(NUM_PORTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  emem_access_checker #(
    .MEM_WORDS(MEM_WORDS),
    .NUM_PORTS(NUM_PORTS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      stall_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] port,
                           input logic [WORD_W-1:0] w);
    int unsigned gap;
    @(negedge clk_i);
    if (sender_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-CMD_W-PORT_W-WORD_W){1'b0}}, w, port, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    sender_idle_en = !(sent >= 700 && sent < 900) && sent < 1650;
    recv_idle_en   = sender_idle_en;
    hold_req       = sent >= 1100;
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] port,
                       input logic [WORD_W-1:0] w);
    logic [CMD_W-1:0] c;
    logic [AW-1:0]    p;
    c = cmd;
    if (port < NUM_PORTS) begin
      p = AW'(ptr_sh[port]);
      if (c == CMD_RDATA && !written[p]) c = CMD_WDATA;
      case (c)
        CMD_CTL: begin
          ptr_sh[port]    = CTL_PTR_W'(w[CTL_PTR_MSB:CTL_PTR_LSB] % MEM_WORDS);
          inc_rd_sh[port] = w[CTL_INC_RD_BIT];
          inc_wr_sh[port] = w[CTL_INC_WR_BIT];
        end
        CMD_WDATA: begin
          written[p] = 1'b1;
          if (inc_wr_sh[port]) ptr_sh[port] = CTL_PTR_W'((p + 1) % MEM_WORDS);
        end
        CMD_RDATA: if (inc_rd_sh[port]) ptr_sh[port] = CTL_PTR_W'((p + 1) % MEM_WORDS);
        default: ;
      endcase
    end
    send_word(c, port, w);
  endtask

  // random control word with the pointer field and step flags forced
  function automatic logic [WORD_W-1:0] ctl_word(int unsigned ptr_field, bit rd, bit wr);
    logic [WORD_W-1:0] w;
    w = $urandom;
    w[CTL_PTR_MSB:CTL_PTR_LSB] = ptr_field[CTL_PTR_W-1:0];
    w[CTL_INC_RD_BIT] = rd;
    w[CTL_INC_WR_BIT] = wr;
    return w;
  endfunction

  task automatic noise_item();
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] w;
    cmd = CMD_W'($urandom_range(0, 3));
    w = $urandom;
    if (cmd == CMD_CTL && $urandom_range(0, 1) == 1)
      w = ctl_word($urandom_range(0, 63), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    issue(cmd, PORT_W'($urandom_range(0, NUM_PORTS - 1)), w);
  endtask

  // write a block through one port, then read it back from the same base
  task automatic run_burst();
    logic [PORT_W-1:0] port;
    int unsigned       base;
    int unsigned       n;
    int unsigned       sel;
    port = PORT_W'($urandom_range(0, NUM_PORTS - 1));
    sel  = $urandom_range(0, 3);
    if (sel < 2) base = $urandom_range(0, 63);
    else if (sel == 2) base = $urandom_range(MEM_WORDS - 8, MEM_WORDS - 1);
    else base = $urandom_range(0, (1 << CTL_PTR_W) - 1);
    n = $urandom_range(1, 8);
    issue(CMD_CTL, port, ctl_word(base, 1'($urandom_range(0, 1)), 1'b1));
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) noise_item();
      issue(CMD_WDATA, port, $urandom);
    end
    issue(CMD_CTL, port, ctl_word(base, 1'b1, 1'($urandom_range(0, 1))));
    repeat (n) issue(CMD_RDATA, port, $urandom);
  endtask

  initial begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      ptr_sh[i]    = '0;
      inc_rd_sh[i] = 1'b0;
      inc_wr_sh[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    issue(CMD_CTL,   2'd0, 32'h0300_0000);
    issue(CMD_WDATA, 2'd0, 32'h0000_0000);
    issue(CMD_WDATA, 2'd0, 32'hffff_ffff);
    issue(CMD_WDATA, 2'd0, 32'ha5a5_5a5a);
    // all control bits set but write step; pointer field 8191 folds to the top word
    issue(CMD_CTL,   2'd1, 32'hfeff_ffff);
    issue(CMD_WDATA, 2'd1, 32'h1234_5678);
    issue(CMD_RDATA, 2'd1, 32'hffff_ffff);
    issue(CMD_RDATA, 2'd1, 32'h0000_0000);
    issue(CMD_RDATA, 2'd1, 32'h5555_5555);
    issue(CMD_CTL,   2'd2, ((MEM_WORDS - 1) << CTL_PTR_LSB) | (1 << CTL_INC_WR_BIT));
    issue(CMD_WDATA, 2'd2, 32'h8000_0001);
    issue(CMD_WDATA, 2'd2, 32'h7fff_fffe);
    issue(CMD_CTL,   2'd3, 2 << CTL_PTR_LSB);
    issue(CMD_RDATA, 2'd3, 32'h0);
    issue(CMD_RDATA, 2'd3, 32'h0);
    issue(CMD_WDATA, 2'd3, 32'h0000_0001);
    issue(CMD_RDATA, 2'd3, 32'h0);
    issue(CMD_NONE,  2'd0, 32'hffff_ffff);
    issue(CMD_NONE,  2'd3, 32'h0000_0000);
    issue(CMD_CTL,   2'd0, (1 << CTL_PTR_LSB) | (1 << CTL_INC_RD_BIT));
    issue(CMD_RDATA, 2'd0, 32'h0);
    issue(CMD_RDATA, 2'd0, 32'h0);
    // pointer field past the depth wraps back to word 1
    issue(CMD_CTL,   2'd2, ((MEM_WORDS + 1) << CTL_PTR_LSB) | (3 << CTL_INC_WR_BIT));
    issue(CMD_RDATA, 2'd2, 32'h0);
    issue(CMD_RDATA, 2'd2, 32'h0);

    while (sent < TOTAL_WORDS) begin
      if ($urandom_range(0, 9) < 7) run_burst();
      else noise_item();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/emem_pkg.sv
design/emem_ram.sv
design/emem_dp.sv
design/emem_ctrl.sv
design/emem_auto_increment_access_port.sv
tb/sv/emem_access_checker.sv
tb/sv/tb.sv
